@@ hw/rtl/aes_rnd_pkg.sv @@
// Shared types, constants and byte functions for the AES encryption round.
package aes_rnd_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t [0:15] block_t;
  typedef logic [3:0] round_t;

  localparam round_t LastRound = 4'd10;
  localparam byte_t  ReducePoly = 8'h1b;
  localparam byte_t  HighHalfMax = 8'h7f;

  localparam byte_t SboxRom [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic byte_t sbox(input byte_t a);
    return SboxRom[a];
  endfunction

  function automatic byte_t xtime(input byte_t a);
    byte_t r;
    r = {a[6:0], 1'b0};
    if (a > HighHalfMax) begin
      r = r ^ ReducePoly;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/aes_rnd_sub_shift.sv @@
// Byte substitution through the S-box followed by the row rotation.
module aes_rnd_sub_shift (
  input  aes_rnd_pkg::block_t state_i,
  output aes_rnd_pkg::block_t shifted_o
);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shifted_o[r * 4 + c] = aes_rnd_pkg::sbox(state_i[r * 4 + ((c + r) % 4)]);
      end
    end
  end

endmodule

@@ hw/rtl/aes_rnd_mix_key.sv @@
// Column mixing, bypassed when the round number is LastRound or above, and the round key addition.
module aes_rnd_mix_key (
  input  aes_rnd_pkg::block_t shifted_i,
  input  aes_rnd_pkg::block_t round_key_i,
  input  aes_rnd_pkg::round_t round_number_i,
  output aes_rnd_pkg::block_t result_o
);

  aes_rnd_pkg::block_t mixed;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      aes_rnd_pkg::byte_t a0, a1, a2, a3, d0, d1, d2, d3;
      a0 = shifted_i[c];
      a1 = shifted_i[c + 4];
      a2 = shifted_i[c + 8];
      a3 = shifted_i[c + 12];
      d0 = aes_rnd_pkg::xtime(a0);
      d1 = aes_rnd_pkg::xtime(a1);
      d2 = aes_rnd_pkg::xtime(a2);
      d3 = aes_rnd_pkg::xtime(a3);
      mixed[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      mixed[c + 4]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      mixed[c + 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      mixed[c + 12] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
  end

  always_comb begin
    if (round_number_i < aes_rnd_pkg::LastRound) begin
      result_o = mixed ^ round_key_i;
    end else begin
      result_o = shifted_i ^ round_key_i;
    end
  end

endmodule

@@ hw/rtl/aes_encrypt_round_core.sv @@
// Top level of the AES encryption round: input register, round logic, result register.
// The core takes one block in every clock cycle and never raises busy. An accepted block
// is held in the input register, passes the S-box lookups and column mixing, and is
// captured in the result register; its result then appears on the out_ ports with out_valid
// high for a single cycle. The receiver must take every result as it appears.
module aes_encrypt_round_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_state_hi,
  input  logic [63:0] in_state_lo,
  input  logic [63:0] in_round_key_hi,
  input  logic [63:0] in_round_key_lo,
  input  logic [3:0]  in_round_number,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);

  logic                valid_r;
  aes_rnd_pkg::block_t state_r;
  aes_rnd_pkg::block_t key_r;
  aes_rnd_pkg::round_t round_r;
  aes_rnd_pkg::block_t shifted;
  aes_rnd_pkg::block_t result_nxt;
  aes_rnd_pkg::block_t result_r;
  logic                out_valid_r;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= accept;
      out_valid_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      state_r <= aes_rnd_pkg::block_t'({in_state_hi, in_state_lo});
      key_r   <= aes_rnd_pkg::block_t'({in_round_key_hi, in_round_key_lo});
      round_r <= in_round_number;
    end
    if (valid_r) begin
      result_r <= result_nxt;
    end
  end

  aes_rnd_sub_shift u_sub_shift (
    .state_i   (state_r),
    .shifted_o (shifted)
  );

  aes_rnd_mix_key u_mix_key (
    .shifted_i      (shifted),
    .round_key_i    (key_r),
    .round_number_i (round_r),
    .result_o       (result_nxt)
  );

  assign out_valid     = out_valid_r;
  assign out_result_hi = result_r[0:7];
  assign out_result_lo = result_r[8:15];

  // Every accepted beat reaches the first stage on the next edge.
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=> valid_r)
    else $error("accepted beat did not enter the first stage");

  // A full first stage always produces a result beat next cycle.
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && valid_r) |=> out_valid_r)
    else $error("result beat lost");

  // No result beat appears without a beat in the first stage.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !valid_r) |=> !out_valid_r)
    else $error("result beat without an input beat");

  // The result register holds steady while the first stage holds no beat.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !valid_r) |=> $stable(result_r))
    else $error("result register changed without a beat");

endmodule
